/* hw/rtl/hsl_gradient_to_rgb_top_defines.svh */
// Assertion macros for the HSL gradient ramp checker.
// No dependencies; included by the checker file.
`ifndef HSL_GRADIENT_TO_RGB_TOP_DEFINES_SVH
`define HSL_GRADIENT_TO_RGB_TOP_DEFINES_SVH

// same-cycle implication
`define HGR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HGR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hgr_pkg.sv */
// Package for the HSL gradient ramp: fixed-point constants, register codes,
// configuration struct and clamp helper. No dependencies.
package hgr_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int IDX_W      = 14;
   localparam int PROD_W     = 2 * Q_W;
   localparam int DIV_STAGES = Q_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = IDX_W;

   localparam int ONE_Q        = 1 << FRAC_BITS;
   localparam int HALF_Q       = ONE_Q / 2;
   localparam int SIXTH_Q      = (ONE_Q + 3) / 6;
   localparam int THIRD_Q      = (ONE_Q + 1) / 3;
   localparam int TWO_THIRDS_Q = (2 * ONE_Q + 1) / 3;

   localparam logic [Q_W-1:0] ONE_V        = Q_W'(ONE_Q);
   localparam logic [Q_W-1:0] HALF_V       = Q_W'(HALF_Q);
   localparam logic [Q_W-1:0] SIXTH_V      = Q_W'(SIXTH_Q);
   localparam logic [Q_W-1:0] THIRD_V      = Q_W'(THIRD_Q);
   localparam logic [Q_W-1:0] TWO_THIRDS_V = Q_W'(TWO_THIRDS_Q);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HUE_START   = 3'd0,
      REG_SAT_START   = 3'd1,
      REG_LIGHT_START = 3'd2,
      REG_HUE_END     = 3'd3,
      REG_SAT_END     = 3'd4,
      REG_LIGHT_END   = 3'd5,
      REG_LAST_STEP   = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      CH_RAMP_UP,
      CH_HIGH,
      CH_RAMP_DOWN,
      CH_LOW
   } chan_sel_type;

   typedef struct packed {
      logic [Q_W-1:0]   hue_start;
      logic [Q_W-1:0]   sat_start;
      logic [Q_W-1:0]   light_start;
      logic [Q_W-1:0]   hue_end;
      logic [Q_W-1:0]   sat_end;
      logic [Q_W-1:0]   light_end;
      logic [IDX_W-1:0] last_step;
   } cfg_type;

   function automatic logic [Q_W-1:0] clamp_one(input logic [Q_W-1:0] v);
      clamp_one = (v > ONE_V) ? ONE_V : v;
   endfunction

endpackage

/* hw/rtl/hgr_ifs.sv */
// Channel interfaces for the HSL gradient ramp: request, response, config.
// Depends on hgr_pkg for field widths.
interface hgr_req_if;
   logic                     valid;
   logic                     ready;
   logic [hgr_pkg::IDX_W-1:0] step_index;
   modport source(output valid, output step_index, input ready);
   modport sink(input valid, input step_index, output ready);
endinterface

interface hgr_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [hgr_pkg::Q_W-1:0] red;
   logic [hgr_pkg::Q_W-1:0] green;
   logic [hgr_pkg::Q_W-1:0] blue;
   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface hgr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hgr_pkg::CSR_IDX_W-1:0]  index;
   logic [hgr_pkg::CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

/* hw/rtl/hsl_gradient_to_rgb_top.sv */
// HSL gradient ramp generator: step index in, RGB color out.
// Accepts one item per cycle while the output is not stalled, sustained by the
// 13-stage divider and the lerp/convert stages all advancing together.
// The last stage is the output register; a stalled output freezes the whole pipe.
// Synchronous active-high reset empties the pipe and loads the default registers.
// Depends on hgr_pkg, hgr_ifs, hgr_divider, hgr_lerp, hgr_rgb.
module hsl_gradient_to_rgb_top (
   input  logic   clock,
   input  logic   reset,
   hgr_req_if.sink   req,
   hgr_rsp_if.source rsp,
   hgr_csr_if.sink   csr
);
   import hgr_pkg::*;

   cfg_type        cfg_ff;
   logic           adv;
   logic           div_vld, lerp_vld, rgb_vld;
   logic [Q_W-1:0] frac, hue, sat, light;

   assign adv       = !rgb_vld || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_start   <= '0;
         cfg_ff.sat_start   <= '0;
         cfg_ff.light_start <= HALF_V;
         cfg_ff.hue_end     <= '0;
         cfg_ff.sat_end     <= '0;
         cfg_ff.light_end   <= HALF_V;
         cfg_ff.last_step   <= '0;
      end else if (csr.valid) begin
         unique case (reg_index_type'(csr.index))
            REG_HUE_START:   cfg_ff.hue_start   <= csr.data[Q_W-1:0];
            REG_SAT_START:   cfg_ff.sat_start   <= csr.data[Q_W-1:0];
            REG_LIGHT_START: cfg_ff.light_start <= csr.data[Q_W-1:0];
            REG_HUE_END:     cfg_ff.hue_end     <= csr.data[Q_W-1:0];
            REG_SAT_END:     cfg_ff.sat_end     <= csr.data[Q_W-1:0];
            REG_LIGHT_END:   cfg_ff.light_end   <= csr.data[Q_W-1:0];
            REG_LAST_STEP:   cfg_ff.last_step   <= csr.data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   hgr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .in_idx    (req.step_index),
      .last_step (cfg_ff.last_step),
      .out_valid (div_vld),
      .out_frac  (frac)
   );

   hgr_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_vld),
      .in_frac   (frac),
      .cfg       (cfg_ff),
      .out_valid (lerp_vld),
      .out_hue   (hue),
      .out_sat   (sat),
      .out_light (light)
   );

   hgr_rgb u_rgb (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lerp_vld),
      .in_hue    (hue),
      .in_sat    (sat),
      .in_light  (light),
      .out_valid (rgb_vld),
      .out_red   (rsp.red),
      .out_green (rsp.green),
      .out_blue  (rsp.blue)
   );

   assign rsp.valid = rgb_vld;

endmodule

/* hw/rtl/hgr_divider.sv */
// Pipelined restoring divider: fraction = min(index, last) * ONE / last
// (0 if last is 0). One quotient bit per stage. Depends on hgr_pkg.
module hgr_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [hgr_pkg::IDX_W-1:0] in_idx,
   input  logic [hgr_pkg::IDX_W-1:0] last_step,
   output logic                      out_valid,
   output logic [hgr_pkg::Q_W-1:0]   out_frac
);
   import hgr_pkg::*;

   logic                 vld_ff  [0:DIV_STAGES];
   logic                 zero_ff [0:DIV_STAGES];
   logic [IDX_W-1:0]     r_ff    [0:DIV_STAGES];
   logic [Q_W-1:0]       q_ff    [0:DIV_STAGES];
   logic                 low_ff;
   logic [IDX_W-1:0]     idx_sat;

   assign idx_sat = (in_idx > last_step) ? last_step : in_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]    <= idx_sat >> 1;
         low_ff     <= idx_sat[0];
         q_ff[0]    <= '0;
         zero_ff[0] <= (last_step == '0);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      logic             bit_in;
      logic [IDX_W:0]   tr;
      logic [IDX_W:0]   sub;
      logic             ge;

      if (k == 0) begin : g_first
         assign bit_in = low_ff;
      end else begin : g_rest
         assign bit_in = 1'b0;
      end

      assign tr  = {r_ff[k], bit_in};
      assign ge  = (tr >= {1'b0, last_step});
      assign sub = tr - {1'b0, last_step};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k+1]    <= ge ? sub[IDX_W-1:0] : tr[IDX_W-1:0];
            q_ff[k+1]    <= {q_ff[k][Q_W-2:0], ge};
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES];
   assign out_frac  = zero_ff[DIV_STAGES] ? '0 : q_ff[DIV_STAGES];

endmodule

/* hw/rtl/hgr_lerp.sv */
// Linear blend of start and end HSL by the ramp fraction, two stages.
// Depends on hgr_pkg.
module hgr_lerp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [hgr_pkg::Q_W-1:0] in_frac,
   input  hgr_pkg::cfg_type        cfg,
   output logic                    out_valid,
   output logic [hgr_pkg::Q_W-1:0] out_hue,
   output logic [hgr_pkg::Q_W-1:0] out_sat,
   output logic [hgr_pkg::Q_W-1:0] out_light
);
   import hgr_pkg::*;

   logic              a_vld_ff, b_vld_ff;
   logic [PROD_W-1:0] ha_ff, hb_ff, sa_ff, sb_ff, la_ff, lb_ff;
   logic [Q_W-1:0]    h_ff, s_ff, l_ff;
   logic [Q_W-1:0]    frac_c;
   logic [PROD_W:0]   h_sum, s_sum, l_sum;

   assign frac_c = ONE_V - in_frac;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ha_ff <= PROD_W'(clamp_one(cfg.hue_start)) * PROD_W'(frac_c);
         hb_ff <= PROD_W'(clamp_one(cfg.hue_end)) * PROD_W'(in_frac);
         sa_ff <= PROD_W'(clamp_one(cfg.sat_start)) * PROD_W'(frac_c);
         sb_ff <= PROD_W'(clamp_one(cfg.sat_end)) * PROD_W'(in_frac);
         la_ff <= PROD_W'(clamp_one(cfg.light_start)) * PROD_W'(frac_c);
         lb_ff <= PROD_W'(clamp_one(cfg.light_end)) * PROD_W'(in_frac);
      end
   end

   assign h_sum = {1'b0, ha_ff} + {1'b0, hb_ff} + (PROD_W+1)'(HALF_V);
   assign s_sum = {1'b0, sa_ff} + {1'b0, sb_ff} + (PROD_W+1)'(HALF_V);
   assign l_sum = {1'b0, la_ff} + {1'b0, lb_ff} + (PROD_W+1)'(HALF_V);

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff <= h_sum[FRAC_BITS +: Q_W];
         s_ff <= s_sum[FRAC_BITS +: Q_W];
         l_ff <= l_sum[FRAC_BITS +: Q_W];
      end
   end

   assign out_valid = b_vld_ff;
   assign out_hue   = h_ff;
   assign out_sat   = s_ff;
   assign out_light = l_ff;

endmodule

/* hw/rtl/hgr_rgb.sv */
// HSL to RGB conversion, four stages: l*s, p/q, ramp products, channel result.
// Depends on hgr_pkg.
module hgr_rgb (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [hgr_pkg::Q_W-1:0] in_hue,
   input  logic [hgr_pkg::Q_W-1:0] in_sat,
   input  logic [hgr_pkg::Q_W-1:0] in_light,
   output logic                    out_valid,
   output logic [hgr_pkg::Q_W-1:0] out_red,
   output logic [hgr_pkg::Q_W-1:0] out_green,
   output logic [hgr_pkg::Q_W-1:0] out_blue
);
   import hgr_pkg::*;

   typedef struct packed {
      chan_sel_type   sel;
      logic [Q_W-1:0] x6;
   } prep_type;

   function automatic prep_type prep(input logic [Q_W-1:0] t);
      prep_type       res;
      logic [Q_W-1:0] x;
      x = '0;
      if (t < SIXTH_V) begin
         res.sel = CH_RAMP_UP;
         x = t;
      end else if (t < HALF_V) begin
         res.sel = CH_HIGH;
      end else if (t < TWO_THIRDS_V) begin
         res.sel = CH_RAMP_DOWN;
         x = TWO_THIRDS_V - t;
      end else begin
         res.sel = CH_LOW;
      end
      res.x6 = (x << 2) + (x << 1);
      prep = res;
   endfunction

   // stage C
   logic              c_vld_ff;
   logic [PROD_W-1:0] ls_prod_ff;
   logic [Q_W-1:0]    c_h_ff, c_s_ff, c_l_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ls_prod_ff <= PROD_W'(in_light) * PROD_W'(in_sat);
         c_h_ff     <= in_hue;
         c_s_ff     <= in_sat;
         c_l_ff     <= in_light;
      end
   end

   // stage D
   logic              d_vld_ff;
   logic [Q_W-1:0]    d_p_ff, d_q_ff, d_h_ff, d_l_ff;
   logic              d_achrom_ff;
   logic [PROD_W:0]   ls_sum;
   logic [Q_W-1:0]    ls;
   logic signed [Q_W+2:0] q_raw, p_raw;
   logic [Q_W-1:0]    q_cl, p_cl;

   assign ls_sum = {1'b0, ls_prod_ff} + (PROD_W+1)'(HALF_V);
   assign ls     = ls_sum[FRAC_BITS +: Q_W];

   always_comb begin
      if (c_l_ff < HALF_V) begin
         q_raw = $signed({3'b000, c_l_ff}) + $signed({3'b000, ls});
      end else begin
         q_raw = $signed({3'b000, c_l_ff}) + $signed({3'b000, c_s_ff})
               - $signed({3'b000, ls});
      end
      if (q_raw < 0) begin
         q_cl = '0;
      end else if (q_raw > $signed({3'b000, ONE_V})) begin
         q_cl = ONE_V;
      end else begin
         q_cl = q_raw[Q_W-1:0];
      end
      p_raw = $signed({2'b00, c_l_ff, 1'b0}) - $signed({3'b000, q_cl});
      if (p_raw < 0) begin
         p_cl = '0;
      end else if (p_raw > $signed({3'b000, ONE_V})) begin
         p_cl = ONE_V;
      end else begin
         p_cl = p_raw[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_p_ff      <= p_cl;
         d_q_ff      <= q_cl;
         d_h_ff      <= c_h_ff;
         d_l_ff      <= c_l_ff;
         d_achrom_ff <= (c_s_ff == '0);
      end
   end

   // stage E
   logic              e_vld_ff;
   logic [PROD_W-1:0] e_prod_ff [0:2];
   chan_sel_type      e_sel_ff  [0:2];
   logic [Q_W-1:0]    e_p_ff, e_q_ff, e_l_ff;
   logic              e_achrom_ff;
   logic [Q_W-1:0]    t_ch [0:2];
   logic [Q_W:0]      t_up;
   logic [Q_W-1:0]    d_diff;
   prep_type          pr [0:2];

   assign t_up     = {1'b0, d_h_ff} + {1'b0, THIRD_V};
   assign t_ch[0]  = (t_up > {1'b0, ONE_V}) ? Q_W'(t_up - {1'b0, ONE_V}) : t_up[Q_W-1:0];
   assign t_ch[1]  = d_h_ff;
   assign t_ch[2]  = (d_h_ff < THIRD_V) ? (d_h_ff + ONE_V - THIRD_V) : (d_h_ff - THIRD_V);
   assign d_diff   = (d_q_ff > d_p_ff) ? (d_q_ff - d_p_ff) : '0;

   for (genvar c = 0; c < 3; c++) begin : g_prep
      assign pr[c] = prep(t_ch[c]);
      always_ff @(posedge clock) begin
         if (adv) begin
            e_prod_ff[c] <= PROD_W'(d_diff) * PROD_W'(pr[c].x6);
            e_sel_ff[c]  <= pr[c].sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_p_ff      <= d_p_ff;
         e_q_ff      <= d_q_ff;
         e_l_ff      <= d_l_ff;
         e_achrom_ff <= d_achrom_ff;
      end
   end

   // stage F
   logic           f_vld_ff;
   logic [Q_W-1:0] f_ch_ff [0:2];
   logic [Q_W-1:0] ch_in   [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_out
      logic [PROD_W:0] rsum;
      logic [Q_W:0]    ramp;
      assign rsum = {1'b0, e_prod_ff[c]} + (PROD_W+1)'(HALF_V);
      assign ramp = {1'b0, e_p_ff} + {1'b0, rsum[FRAC_BITS +: Q_W]};
      always_comb begin
         if (e_achrom_ff) begin
            ch_in[c] = e_l_ff;
         end else begin
            case (e_sel_ff[c]) inside
               CH_RAMP_UP, CH_RAMP_DOWN: begin
                  ch_in[c] = (ramp > {1'b0, ONE_V}) ? ONE_V : ramp[Q_W-1:0];
               end
               CH_HIGH: ch_in[c] = e_q_ff;
               default: ch_in[c] = e_p_ff;
            endcase
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            f_ch_ff[c] <= clamp_one(ch_in[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= in_valid;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
      end
   end

   assign out_valid = f_vld_ff;
   assign out_red   = f_ch_ff[0];
   assign out_green = f_ch_ff[1];
   assign out_blue  = f_ch_ff[2];

endmodule

/* hw/rtl/hgr_checker.sv */
// Port-level checker for the HSL gradient ramp, bound to the top level.
// Depends on hsl_gradient_to_rgb_top_defines.svh and hgr_pkg.
`include "hsl_gradient_to_rgb_top_defines.svh"

module hgr_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [hgr_pkg::Q_W-1:0] rsp_red,
   input logic [hgr_pkg::Q_W-1:0] rsp_green,
   input logic [hgr_pkg::Q_W-1:0] rsp_blue
);
   import hgr_pkg::*;

   `HGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "stalled item changed")
   `HGR_ASSERT_IMPL(a_req_ready, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "input ready does not follow output slot")
   `HGR_ASSERT_IMPL(a_rsp_range, clock, reset, rsp_valid, rsp_red <= ONE_V && rsp_green <= ONE_V && rsp_blue <= ONE_V, "channel above full scale")

endmodule

bind hsl_gradient_to_rgb_top hgr_checker u_hgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_red   (rsp.red),
   .rsp_green (rsp.green),
   .rsp_blue  (rsp.blue)
);

/* tb/tb_hsl_gradient_to_rgb_top.sv */
// Testbench for the HSL gradient ramp: programs ramps, drives step indexes and
// checks each RGB item against a fixed-point predictor in a scoreboard class.
// Depends on hgr_pkg, hgr_ifs and hsl_gradient_to_rgb_top.
module tb_hsl_gradient_to_rgb_top;
   import hgr_pkg::*;

   typedef struct {
      logic [Q_W-1:0] red;
      logic [Q_W-1:0] green;
      logic [Q_W-1:0] blue;
   } color_type;

   class ramp_scoreboard;
      cfg_type        cfg;
      color_type      pending[$];
      int             errors;

      function new();
         errors = 0;
         cfg = '0;
         cfg.light_start = Q_W'(HALF_Q);
         cfg.light_end = Q_W'(HALF_Q);
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_HUE_START:   cfg.hue_start = val[Q_W-1:0];
            REG_SAT_START:   cfg.sat_start = val[Q_W-1:0];
            REG_LIGHT_START: cfg.light_start = val[Q_W-1:0];
            REG_HUE_END:     cfg.hue_end = val[Q_W-1:0];
            REG_SAT_END:     cfg.sat_end = val[Q_W-1:0];
            REG_LIGHT_END:   cfg.light_end = val[Q_W-1:0];
            REG_LAST_STEP:   cfg.last_step = val;
            default: ;
         endcase
      endfunction

      function longint clampq(longint v);
         if (v < 0) return 0;
         if (v > ONE_Q) return ONE_Q;
         return v;
      endfunction

      function longint blend(longint a, longint b, longint f);
         return (clampq(a) * (ONE_Q - f) + clampq(b) * f + HALF_Q) >>> FRAC_BITS;
      endfunction

      function longint hue_ramp(longint p, longint q, longint t);
         longint d;
         d = (q > p) ? q - p : 0;
         if (t < 0) t += ONE_Q;
         if (t > ONE_Q) t -= ONE_Q;
         if (t < SIXTH_Q) return clampq(p + ((d * 6 * t + HALF_Q) >>> FRAC_BITS));
         if (t < HALF_Q) return q;
         if (t < TWO_THIRDS_Q)
            return clampq(p + ((d * 6 * (TWO_THIRDS_Q - t) + HALF_Q) >>> FRAC_BITS));
         return p;
      endfunction

      function void note_step(logic [IDX_W-1:0] step);
         longint last, idx, f, h, s, l, r, g, b, ls, q, p;
         color_type c;
         last = cfg.last_step;
         idx = step;
         f = 0;
         if (last != 0) begin
            if (idx > last) idx = last;
            f = (idx << FRAC_BITS) / last;
         end
         h = blend(cfg.hue_start, cfg.hue_end, f);
         s = blend(cfg.sat_start, cfg.sat_end, f);
         l = blend(cfg.light_start, cfg.light_end, f);
         if (s == 0) begin
            r = l; g = l; b = l;
         end else begin
            ls = (l * s + HALF_Q) >>> FRAC_BITS;
            q = clampq((l < HALF_Q) ? l + ls : l + s - ls);
            p = clampq(2 * l - q);
            r = hue_ramp(p, q, h + THIRD_Q);
            g = hue_ramp(p, q, h);
            b = hue_ramp(p, q, h - THIRD_Q);
         end
         c.red = Q_W'(clampq(r));
         c.green = Q_W'(clampq(g));
         c.blue = Q_W'(clampq(b));
         pending.push_back(c);
      endfunction

      function void check_color(logic [Q_W-1:0] r, logic [Q_W-1:0] g, logic [Q_W-1:0] b);
         color_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item r=%0d g=%0d b=%0d", $time, r, g, b);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r !== e.red || g !== e.green || b !== e.blue) begin
            $display("%0t: expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
                     $time, e.red, e.green, e.blue, r, g, b);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   hgr_req_if req();
   hgr_rsp_if rsp();
   hgr_csr_if csr();
   ramp_scoreboard sb = new();
   bit hold_off = 0;

   hsl_gradient_to_rgb_top u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                                  .csr(csr));

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_color(rsp.red, rsp.green, rsp.blue);
   end

   initial begin
      int gap;
      rsp.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp.ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp.ready <= (gap == 0);
         @(negedge clock);
         repeat (gap > 0 ? gap - 1 : 0) @(negedge clock);
      end
   end

   task automatic send_step(logic [IDX_W-1:0] step, bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1;
      req.step_index <= step;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_step(step);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr.valid <= 0;
   endtask

   task automatic program_ramp(int hs, int ss, int lsv, int he, int se, int le, int last);
      write_csr(REG_HUE_START, CSR_DATA_W'(hs));
      write_csr(REG_SAT_START, CSR_DATA_W'(ss));
      write_csr(REG_LIGHT_START, CSR_DATA_W'(lsv));
      write_csr(REG_HUE_END, CSR_DATA_W'(he));
      write_csr(REG_SAT_END, CSR_DATA_W'(se));
      write_csr(REG_LIGHT_END, CSR_DATA_W'(le));
      write_csr(REG_LAST_STEP, CSR_DATA_W'(last));
   endtask

   function automatic int rand_q();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 0;
      if (k == 1) return ONE_Q;
      if (k == 2) return $urandom_range(ONE_Q + 1, 8191);
      return $urandom_range(0, ONE_Q);
   endfunction

   initial begin
      int last;
      int step;
      req.valid = 0;
      req.step_index = '0;
      csr.valid = 0;
      csr.index = REG_HUE_START;
      csr.data = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      send_step(IDX_W'(0), 1'b0);
      send_step(14'h3FFF, 1'b0);
      drain();
      program_ramp(0, 4096, 0, 4096, 4096, 4096, 16);
      for (int i = 0; i <= 17; i++) send_step(IDX_W'(i), 1'b0);
      send_step(14'h3FFF, 1'b0);
      drain();
      program_ramp(8191, 8191, 8191, 8191, 0, 8191, 14'h3FFF);
      send_step(IDX_W'(0), 1'b0);
      send_step(IDX_W'(8191), 1'b0);
      send_step(14'h3FFF, 1'b0);
      drain();

      for (int phase = 0; phase < 16; phase++) begin
         case (phase % 4)
            0: last = $urandom_range(1, 63);
            1: last = 0;
            2: last = 14'h3FFF;
            default: last = $urandom_range(0, 16383);
         endcase
         program_ramp(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), last);
         if (phase == 5) hold_off = 1;
         for (int n = 0; n < 50; n++) begin
            if (last != 0 && $urandom_range(0, 3) != 0) step = $urandom_range(0, last);
            else step = $urandom_range(0, 16383);
            send_step(IDX_W'(step), phase != 5);
         end
         if (phase == 9) begin
            req.valid <= 0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         drain();
      end

      if (sb.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/hgr_pkg.sv
hw/rtl/hgr_ifs.sv
hw/rtl/hgr_divider.sv
hw/rtl/hgr_lerp.sv
hw/rtl/hgr_rgb.sv
hw/rtl/hsl_gradient_to_rgb_top.sv
hw/rtl/hgr_checker.sv
tb/tb_hsl_gradient_to_rgb_top.sv
